// File: hdl/square_matrix_multiply_average_assert.svh
// Assertion macros for the square matrix multiply and average block.
// Used by the top level; expects clk and rst in scope.
`ifndef SQUARE_MATRIX_MULTIPLY_AVERAGE_ASSERT_SVH
`define SQUARE_MATRIX_MULTIPLY_AVERAGE_ASSERT_SVH

// same-cycle implication
`define SMMA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/smma_pkg.sv
// Shared types and constants for the square matrix multiply and average block.
// No dependencies.
`timescale 1ns / 1ps

package smma_pkg;

  localparam int ELEM_W = 9;
  localparam int ACC_W  = 21;
  localparam int SUM_W  = 40;
  localparam int RES_W  = 32;
  localparam int DIVR_W = 11;
  localparam int IDX_W  = 3;

  localparam logic [DIVR_W-1:0] DIVISOR_RESET = 11'd1000;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_AVG  = 1'b1;
  localparam logic KIND_PROD = 1'b0;
  localparam logic KIND_AVG  = 1'b1;
  localparam logic REG_AVG_DIVISOR = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FEED,
    ST_FLUSH,
    ST_DRAIN,
    ST_AVG_RD,
    ST_AVG_LD,
    ST_AVG_DIV,
    ST_AVG_OUT
  } state_t;

  // operand token that walks along the cell chain
  typedef struct packed {
    logic                     valid;
    logic                     first;
    logic [IDX_W-1:0]         t;
    logic signed [ELEM_W-1:0] x;
  } tok_t;

  // controls broadcast to every cell
  typedef struct packed {
    logic             shift;
    logic             y_we;
    logic [IDX_W-1:0] y_row;
    logic [IDX_W-1:0] y_col;
  } cell_ctl_t;

endpackage

// File: hdl/smma_cell.sv
// One multiply-accumulate cell of the chain: holds one column of Y and one Z sum.
// Depends on smma_pkg.
`timescale 1ns / 1ps

module smma_cell import smma_pkg::*; #(
  parameter int DIM = 8,
  parameter int IDX = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cell_ctl_t                ctl,
  input  logic signed [ELEM_W-1:0] y_value,
  input  tok_t                     tok_in,
  output tok_t                     tok_out,
  input  logic signed [ACC_W-1:0]  acc_in,
  output logic signed [ACC_W-1:0]  acc_out
);

  localparam int CW = (DIM > 1) ? $clog2(DIM) : 1;

  logic signed [ELEM_W-1:0]   y_store [DIM];
  logic signed [2*ELEM_W-1:0] prod;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [ACC_W-1:0]    acc;
  tok_t                       tok;

  assign prod     = tok_in.x * y_store[tok_in.t[CW-1:0]];
  assign prod_ext = {{(ACC_W-2*ELEM_W){prod[2*ELEM_W-1]}}, prod};

  always_ff @(posedge clk) begin
    if (ctl.y_we && ctl.y_col[CW-1:0] == CW'(IDX)) begin
      y_store[ctl.y_row[CW-1:0]] <= y_value;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in.valid) begin
      acc <= tok_in.first ? prod_ext : acc + prod_ext;
    end else if (ctl.shift) begin
      // move sums one cell towards the output end
      acc <= acc_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else begin
      tok.valid <= tok_in.valid;
    end
    tok.first <= tok_in.first;
    tok.t     <= tok_in.t;
    tok.x     <= tok_in.x;
  end

  assign tok_out = tok;
  assign acc_out = acc;

endmodule

// File: hdl/smma_div.sv
// Restoring divider, one quotient bit per cycle, for the average pass.
// Depends on smma_pkg.
`timescale 1ns / 1ps

module smma_div import smma_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [DIVR_W-1:0] divisor,
  output logic              busy,
  output logic [SUM_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [CNT_W-1:0]  cnt;
  logic [DIVR_W-1:0] rem;
  logic [DIVR_W-1:0] dvs;
  logic [SUM_W-1:0]  quo;
  logic [DIVR_W:0]   rem_sh;
  logic              fits;

  assign rem_sh = {rem, quo[SUM_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CNT_W'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= CNT_W'(SUM_W);
      rem <= '0;
      quo <= dividend;
      dvs <= (divisor == '0) ? DIVR_W'(1) : divisor;
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      rem <= fits ? DIVR_W'(rem_sh - {1'b0, dvs}) : rem_sh[DIVR_W-1:0];
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

// File: hdl/square_matrix_multiply_average.sv
// Top level: loads X and Y, multiplies on a chain of DIM cells, keeps running sums.
// Depends on smma_pkg, smma_cell, smma_div and square_matrix_multiply_average_assert.svh.
`timescale 1ns / 1ps
//
// channel  direction  handshake              payload
// in       sink       in_valid / in_ready    func, element_value
// out      source     out_valid / out_ready  result_kind, row_index, column_index,
//                                            result_value, last_of_run
// cfg      APB slave  psel / penable / pready paddr, pwdata, prdata
//
// Load items fill X first, then Y. The last Y element starts the product: per row of Z,
// X reads feed the cell chain, the chain is flushed and the sums are shifted out.
// An average item runs each element through the one-bit-per-cycle divider.
// Output stalls hold the drain; the next item is taken once the pass ends.
// Reset is synchronous and clears all running sums at once.

module square_matrix_multiply_average import smma_pkg::*; #(
  parameter int DIM = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     func,
  input  logic signed [ELEM_W-1:0] element_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     result_kind,
  output logic [IDX_W-1:0]         row_index,
  output logic [IDX_W-1:0]         column_index,
  output logic signed [RES_W-1:0]  result_value,
  output logic                     last_of_run,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int CELLS = DIM * DIM;
  localparam int CW    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int AW    = $clog2(CELLS);
  localparam logic [CW-1:0] LASTC = CW'(DIM - 1);
  localparam logic [AW-1:0] LASTK = AW'(CELLS - 1);

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W-1:0] s,
                                                      input logic signed [ACC_W-1:0] z);
    logic signed [SUM_W:0] t;
    t = {s[SUM_W-1], s} + {{(SUM_W+1-ACC_W){z[ACC_W-1]}}, z};
    if (t[SUM_W] != t[SUM_W-1]) begin
      return t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return t[SUM_W-1:0];
  endfunction

  function automatic logic signed [RES_W-1:0] sat_avg(input logic [SUM_W-1:0] q,
                                                      input logic neg);
    logic over;
    over = |q[SUM_W-1:RES_W];
    if (neg) begin
      if (over || (q[RES_W-1] && |q[RES_W-2:0])) begin
        return {1'b1, {(RES_W-1){1'b0}}};
      end
      return -q[RES_W-1:0];
    end
    if (over || q[RES_W-1]) begin
      return {1'b0, {(RES_W-1){1'b1}}};
    end
    return q[RES_W-1:0];
  endfunction

  state_t state, state_next;

  // configuration
  logic [DIVR_W-1:0] avg_divisor;
  logic              cfg_wr;

  // load position
  logic [AW-1:0] lidx;
  logic [CW-1:0] lrow, lcol;
  logic          lphase;

  // compute counters
  logic [CW-1:0] r, t, col;
  logic [AW-1:0] kidx, rbase;

  logic in_acc, load_acc, avg_acc, last_load;
  logic issue, drain_emit, avg_emit, out_free, out_load, div_start;

  logic signed [ELEM_W-1:0] left_mem [CELLS];
  logic signed [ELEM_W-1:0] x_rd;
  logic                     tok0_v, tok0_first;
  logic [CW-1:0]            tok0_t;

  logic signed [SUM_W-1:0] sum_mem [CELLS];
  logic [CELLS-1:0]        sum_valid;
  logic signed [SUM_W-1:0] sum_rd;
  logic                    sum_rd_vld;
  logic signed [SUM_W-1:0] sum_cur;
  logic                    sa_v;
  logic [AW-1:0]           sa_k;
  logic signed [ACC_W-1:0] sa_z;

  logic                    avg_neg;
  logic                    div_busy;
  logic [SUM_W-1:0]        div_q;

  cell_ctl_t               ctl;
  tok_t                    chain [DIM+1];
  logic signed [ACC_W-1:0] accs [DIM+1];
  logic [DIM-1:0]          chain_v;
  logic                    chain_busy;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && paddr[2] == REG_AVG_DIVISOR;
  assign prdata = (paddr[2] == REG_AVG_DIVISOR) ? {{(32-DIVR_W){1'b0}}, avg_divisor} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_divisor <= DIVISOR_RESET;
    end else if (cfg_wr) begin
      avg_divisor <= pwdata[DIVR_W-1:0];
    end
  end

  // ---------------- control ----------------
  assign in_ready  = state == ST_IDLE && !sa_v;
  assign in_acc    = in_valid && in_ready;
  assign load_acc  = in_acc && func == FUNC_LOAD;
  assign avg_acc   = in_acc && func == FUNC_AVG;
  assign last_load = lphase && lidx == LASTK;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (avg_acc) begin
          state_next = ST_AVG_RD;
        end else if (load_acc && last_load) begin
          state_next = ST_FEED;
        end
      end
      ST_FEED:    if (t == LASTC) state_next = ST_FLUSH;
      ST_FLUSH:   if (!chain_busy) state_next = ST_DRAIN;
      ST_DRAIN: begin
        if (out_free && col == LASTC) begin
          state_next = (r == LASTC) ? ST_IDLE : ST_FEED;
        end
      end
      ST_AVG_RD:  state_next = ST_AVG_LD;
      ST_AVG_LD:  state_next = ST_AVG_DIV;
      ST_AVG_DIV: if (!div_busy) state_next = ST_AVG_OUT;
      ST_AVG_OUT: begin
        if (out_free) begin
          state_next = (kidx == LASTK) ? ST_IDLE : ST_AVG_RD;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    issue      = 1'b0;
    drain_emit = 1'b0;
    avg_emit   = 1'b0;
    div_start  = 1'b0;
    case (state)
      ST_FEED:    issue      = 1'b1;
      ST_DRAIN:   drain_emit = out_free;
      ST_AVG_LD:  div_start  = 1'b1;
      ST_AVG_OUT: avg_emit   = out_free;
      default:    issue      = 1'b0;
    endcase
  end

  assign out_load = drain_emit || avg_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lidx   <= '0;
      lrow   <= '0;
      lcol   <= '0;
      lphase <= 1'b0;
      r      <= '0;
      t      <= '0;
      col    <= '0;
      kidx   <= '0;
      rbase  <= '0;
      tok0_v <= 1'b0;
      sa_v   <= 1'b0;
    end else begin
      tok0_v <= issue;
      sa_v   <= drain_emit;
      if (load_acc) begin
        if (lidx == LASTK) begin
          lidx   <= '0;
          lrow   <= '0;
          lcol   <= '0;
          lphase <= !lphase;
        end else begin
          lidx <= lidx + AW'(1);
          if (lcol == LASTC) begin
            lcol <= '0;
            lrow <= lrow + CW'(1);
          end else begin
            lcol <= lcol + CW'(1);
          end
        end
      end
      if (in_acc) begin
        r     <= '0;
        t     <= '0;
        col   <= '0;
        kidx  <= '0;
        rbase <= '0;
      end
      if (issue) begin
        t <= (t == LASTC) ? '0 : t + CW'(1);
      end
      if (out_load) begin
        kidx <= kidx + AW'(1);
        if (col == LASTC) begin
          col   <= '0;
          r     <= r + CW'(1);
          rbase <= rbase + AW'(DIM);
        end else begin
          col <= col + CW'(1);
        end
      end
    end
  end

  // ---------------- X store ----------------
  always_ff @(posedge clk) begin
    if (load_acc && !lphase) begin
      left_mem[lidx] <= element_value;
    end
    x_rd       <= left_mem[AW'(rbase + AW'(t))];
    tok0_first <= t == '0;
    tok0_t     <= t;
  end

  // ---------------- cell chain ----------------
  assign ctl.shift = drain_emit;
  assign ctl.y_we  = load_acc && lphase;
  assign ctl.y_row = IDX_W'(lrow);
  assign ctl.y_col = IDX_W'(lcol);

  assign chain[0].valid = tok0_v;
  assign chain[0].first = tok0_first;
  assign chain[0].t     = IDX_W'(tok0_t);
  assign chain[0].x     = x_rd;
  assign accs[DIM]      = '0;

  for (genvar c = 0; c < DIM; c++) begin : g_cell
    smma_cell #(.DIM(DIM), .IDX(c)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .y_value (element_value),
      .tok_in  (chain[c]),
      .tok_out (chain[c+1]),
      .acc_in  (accs[c+1]),
      .acc_out (accs[c])
    );
    assign chain_v[c] = chain[c+1].valid;
  end

  assign chain_busy = tok0_v || (|chain_v);

  // ---------------- running sums ----------------
  assign sum_cur = sum_rd_vld ? sum_rd : '0;

  always_ff @(posedge clk) begin
    sum_rd     <= sum_mem[kidx];
    sum_rd_vld <= sum_valid[kidx];
    sa_k       <= kidx;
    sa_z       <= accs[0];
    if (sa_v) begin
      sum_mem[sa_k] <= sat_sum(sum_cur, sa_z);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= '0;
    end else begin
      if (sa_v) begin
        sum_valid[sa_k] <= 1'b1;
      end
      // drop the entry once it has been read for its average
      if (div_start) begin
        sum_valid[kidx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      avg_neg <= sum_cur[SUM_W-1];
    end
  end

  smma_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_cur[SUM_W-1] ? SUM_W'(-sum_cur) : SUM_W'(sum_cur)),
    .divisor  (avg_divisor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_kind  <= drain_emit ? KIND_PROD : KIND_AVG;
      row_index    <= IDX_W'(r);
      column_index <= IDX_W'(col);
      last_of_run  <= r == LASTC && col == LASTC;
      result_value <= drain_emit ? {{(RES_W-ACC_W){accs[0][ACC_W-1]}}, accs[0]}
                                 : sat_avg(div_q, avg_neg);
    end
  end

  `include "square_matrix_multiply_average_assert.svh"

  `SMMA_ASSERT_NEXT(a_last_prod_idle, drain_emit && r == LASTC && col == LASTC, state == ST_IDLE, "product pass did not end after last element")
  `SMMA_ASSERT_NOW(a_idle_chain_quiet, state == ST_IDLE, !chain_busy, "cell chain busy while idle")
  `SMMA_ASSERT_NOW(a_sum_write_from_drain, sa_v, $past(state) == ST_DRAIN, "running sum written outside drain")
  `SMMA_ASSERT_NEXT(a_div_started, state == ST_AVG_LD, div_busy, "divider not started for average")

endmodule
